// ===== design/dpd_pkg.sv =====
// Shared types, constants and codes for the delimited packet deframer.
package dpd_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH + 1);

    localparam logic [7:0] FILLER_BYTE = 8'hFF;
    localparam logic [5:0] SEP_MAX     = 6'd63;

    localparam logic [7:0] START_CHAR_RESET     = 8'd60;
    localparam logic [7:0] SEPARATOR_CHAR_RESET = 8'd44;
    localparam logic [7:0] END_CHAR_RESET       = 8'd62;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_START     = 2'd0;
    localparam cfg_idx_t CFG_SEPARATOR = 2'd1;
    localparam cfg_idx_t CFG_END       = 2'd2;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] separator_char;
        logic [7:0] end_char;
    } cfg_t;

    typedef enum logic [1:0] {
        EV_IGNORED  = 2'd0,
        EV_STORED   = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_OVERFLOW = 2'd3
    } event_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] stored_byte;
        logic [5:0] stored_index;
        logic [6:0] packet_length;
        logic [5:0] field_separators;
    } result_t;

endpackage

// ===== design/delimited_packet_deframer.sv =====
// Top level of the delimited packet deframer: configuration, input and result stages.
// An accepted byte waits in the input register, then moves into the result register,
// which offers its result transaction to the consumer.
// Throughput: one byte per cycle unless a full result register waits on res_ready;
// the framing state is decided combinationally between the input and result registers.
// Reset (rst_n low, asynchronous): both stages empty, hunting for a start
// character, index and separator count cleared, registers back to '<' ',' '>'.
module delimited_packet_deframer
    import dpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration writes
    input  logic       cfg_write,
    input  cfg_idx_t   cfg_index,
    input  logic [7:0] cfg_data,
    // received bytes
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    // result transactions
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] event_res,
    output logic [7:0] stored_byte,
    output logic [5:0] stored_index,
    output logic [6:0] packet_length,
    output logic [5:0] field_separators
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    result_t    result;
    result_t    res_data;

    // Decode configuration writes; an index beyond the register list is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START:     cfg_next.start_char     = cfg_data;
                CFG_SEPARATOR: cfg_next.separator_char = cfg_data;
                CFG_END:       cfg_next.end_char       = cfg_data;
                default:       cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char     <= START_CHAR_RESET;
            cfg_reg.separator_char <= SEPARATOR_CHAR_RESET;
            cfg_reg.end_char       <= END_CHAR_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the accepted byte until the framing logic can take it.
    dpd_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    // Framing state advances only when the byte moves into the result register.
    dpd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_byte (in_byte),
        .advance (advance),
        .result  (result)
    );

    // Result register decouples the consumer from the input side.
    dpd_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .result    (result),
        .advance   (advance),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign event_res        = res_data.event_res;
    assign stored_byte      = res_data.stored_byte;
    assign stored_index     = res_data.stored_index;
    assign packet_length    = res_data.packet_length;
    assign field_separators = res_data.field_separators;

endmodule

// ===== design/dpd_input_stage.sv =====
// Input register of the deframer: holds one received byte until it advances.
module dpd_input_stage
    import dpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // free when empty or when the held byte leaves this cycle
    assign rx_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_ready)
        begin
            in_valid_next = rx_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_byte  = in_byte_reg;

endmodule

// ===== design/dpd_core.sv =====
// Framing state and per-byte decision logic of the deframer.
module dpd_core
    import dpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic [7:0] in_byte,
    input  logic       advance,
    output result_t    result
);

    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] write_index_next;
    logic             in_packet_reg;
    logic             in_packet_next;
    logic [5:0]       sep_count_reg;
    logic [5:0]       sep_count_next;

    logic             opens;
    logic             active;
    logic             restart;
    logic [IDX_W-1:0] idx_after;
    logic [5:0]       sep_after;
    logic             sep_hit;
    logic [5:0]       sep_total;

    always_comb
    begin
        opens = (write_index_reg == '0)
             && ((in_byte == cfg.start_char) || (cfg.start_char == 8'd0));
        active = in_packet_reg || opens;

        // start character inside a packet: begin again
        restart = active && (write_index_reg != '0) && (cfg.start_char != 8'd0)
               && (in_byte == cfg.start_char);
        idx_after = restart ? '0 : write_index_reg;
        sep_after = restart ? 6'd0 : sep_count_reg;

        sep_hit = active && (idx_after != '0) && (cfg.separator_char != 8'd0)
               && (in_byte == cfg.separator_char) && (sep_after < SEP_MAX);
        sep_total = sep_hit ? sep_after + 6'd1 : sep_after;

        result           = '0;
        result.event_res = EV_IGNORED;
        write_index_next = idx_after;
        sep_count_next   = sep_total;
        in_packet_next   = active;

        if (active && (in_byte == cfg.end_char))
        begin
            result.event_res        = EV_COMPLETE;
            result.packet_length    = 7'(idx_after);
            result.field_separators = sep_total;
            write_index_next        = '0;
            sep_count_next          = 6'd0;
            in_packet_next          = 1'b0;
        end
        else if (active && (in_byte != FILLER_BYTE))
        begin
            if (idx_after >= IDX_W'(BUFFER_DEPTH))
            begin
                // buffer full: drop the byte and resume hunting
                result.event_res = EV_OVERFLOW;
                write_index_next = '0;
                sep_count_next   = 6'd0;
                in_packet_next   = 1'b0;
            end
            else
            begin
                result.event_res    = EV_STORED;
                result.stored_byte  = in_byte;
                result.stored_index = 6'(idx_after);
                write_index_next    = idx_after + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            in_packet_reg   <= 1'b0;
            sep_count_reg   <= 6'd0;
        end
        else if (advance)
        begin
            write_index_reg <= write_index_next;
            in_packet_reg   <= in_packet_next;
            sep_count_reg   <= sep_count_next;
        end
    end

endmodule

// ===== design/dpd_output_stage.sv =====
// Result register of the deframer: holds one result transaction until taken.
module dpd_output_stage
    import dpd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t result,
    output logic    advance,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res_data
);

    logic    res_valid_reg;
    logic    res_valid_next;
    result_t res_data_reg;

    // move a byte forward when the result slot is empty or being emptied
    assign advance = in_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
